[rtl/assert_macros.svh]
// Assertion helpers shared by the RTL
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

[rtl/stksrch_pkg.sv]
package stksrch_pkg;

    localparam int DATA_W    = 32;
    localparam int MODE_W    = 2;
    localparam int STAT_W    = 2;
    localparam int POS_W     = 6;
    localparam int OCC_W     = 7;
    localparam int DEPTH_DEF = 64;

    localparam logic [MODE_W-1:0] MODE_PUSH   = 2'd0;
    localparam logic [MODE_W-1:0] MODE_POP    = 2'd1;
    localparam logic [MODE_W-1:0] MODE_SEARCH = 2'd2;
    localparam logic [MODE_W-1:0] MODE_MINMAX = 2'd3;

    localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

    localparam logic signed [DATA_W-1:0] WORD_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [DATA_W-1:0] WORD_MIN = 32'sh8000_0000;

    typedef logic signed [DATA_W-1:0] t_word;

endpackage

[rtl/array_stack_with_search_core.sv]
// LIFO stack of signed 32-bit words with search and min/max scans.
// Command channel: start with i_mode and i_data is taken on a rising edge
// where busy is low. Modes: push, pop, search for key, min and max.
// Result channel: o_valid marks one cycle holding a result; o_last flags the
// final result of a command. The receiver cannot hold results off.
// Command flow, n being the stored word count:
//   push, and any command on an empty stack: result the cycle after accept.
//   pop: one memory read; the POP state registers the word from the RAM read register.
//   search, min/max: the scan reads one slot per cycle, over all n slots, through
//   the single read port of the word memory, top slot first, and a final FLUSH
//   state emits the held match or the extremes.
// Search results come one per matching slot, top to bottom (one not-found result if none);
// each match is held until the next match or the flush so the final one carries o_last.
// Reset empties the stack and drops any command in flight; memory contents
// are left as they are and only written slots are ever read.
`include "assert_macros.svh"

module array_stack_with_search_core #(
    parameter int DEPTH = stksrch_pkg::DEPTH_DEF
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  start,
    output logic                                  busy,
    input  logic [stksrch_pkg::MODE_W-1:0]        i_mode,
    input  logic signed [stksrch_pkg::DATA_W-1:0] i_data,
    output logic                                  o_valid,
    output logic [stksrch_pkg::STAT_W-1:0]        o_status,
    output logic signed [stksrch_pkg::DATA_W-1:0] o_value,
    output logic signed [stksrch_pkg::DATA_W-1:0] o_max_value,
    output logic                                  o_found,
    output logic [stksrch_pkg::POS_W-1:0]         o_position,
    output logic [stksrch_pkg::OCC_W-1:0]         o_occupancy,
    output logic                                  o_last
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_POP   = 2'd1;
    localparam logic [1:0] ST_SCAN  = 2'd2;
    localparam logic [1:0] ST_FLUSH = 2'd3;

    logic [1:0]                        r_state, n_state;
    logic [CW-1:0]                     r_cnt, n_cnt;
    logic [AW-1:0]                     r_addr, n_addr;
    stksrch_pkg::t_word                r_key, n_key;
    logic                              r_is_mm, n_is_mm;
    stksrch_pkg::t_word                r_lo, n_lo;
    stksrch_pkg::t_word                r_hi, n_hi;
    logic                              r_pend, n_pend;
    logic [AW-1:0]                     r_pend_pos, n_pend_pos;

    logic                              r_valid, n_valid;
    logic [stksrch_pkg::STAT_W-1:0]    r_status, n_status;
    stksrch_pkg::t_word                r_value, n_value;
    stksrch_pkg::t_word                r_max, n_max;
    logic                              r_found, n_found;
    logic [AW-1:0]                     r_pos, n_pos;
    logic                              r_last, n_last;

    logic                              w_we;
    logic [AW-1:0]                     w_top;
    logic [AW-1:0]                     w_raddr;
    stksrch_pkg::t_word                w_rdata;

    logic                              w_pop_st;
    logic                              w_push_ok;
    logic [CW-1:0]                     w_cnt_inc;
    logic                              w_match_out;
    logic                              w_pos_ok;

    assign w_top   = AW'(r_cnt - CW'(1));
    assign w_raddr = (r_state == ST_IDLE) ? w_top : (r_addr - AW'(1));

    stksrch_ram #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (AW'(r_cnt)),
        .i_wdata (i_data),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_addr     = r_addr;
        n_key      = r_key;
        n_is_mm    = r_is_mm;
        n_lo       = r_lo;
        n_hi       = r_hi;
        n_pend     = r_pend;
        n_pend_pos = r_pend_pos;
        n_valid    = 1'b0;
        n_status   = stksrch_pkg::STAT_OK;
        n_value    = '0;
        n_max      = '0;
        n_found    = 1'b0;
        n_pos      = '0;
        n_last     = 1'b1;
        w_we       = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    case (i_mode)
                        stksrch_pkg::MODE_PUSH: begin
                            n_valid = 1'b1;
                            if (r_cnt == CW'(DEPTH)) begin
                                n_status = stksrch_pkg::STAT_FULL;
                            end else begin
                                w_we  = 1'b1;
                                n_cnt = r_cnt + CW'(1);
                            end
                        end
                        stksrch_pkg::MODE_POP: begin
                            if (r_cnt == '0) begin
                                n_valid  = 1'b1;
                                n_status = stksrch_pkg::STAT_EMPTY;
                            end else begin
                                n_cnt   = r_cnt - CW'(1);
                                n_state = ST_POP;
                            end
                        end
                        default: begin
                            n_key   = i_data;
                            n_is_mm = (i_mode == stksrch_pkg::MODE_MINMAX);
                            n_lo    = stksrch_pkg::WORD_MAX;
                            n_hi    = stksrch_pkg::WORD_MIN;
                            n_pend  = 1'b0;
                            if (r_cnt == '0) begin
                                n_valid = 1'b1;
                                if (i_mode == stksrch_pkg::MODE_MINMAX) begin
                                    n_value = stksrch_pkg::WORD_MAX;
                                    n_max   = stksrch_pkg::WORD_MIN;
                                end
                            end else begin
                                n_addr  = w_top;
                                n_state = ST_SCAN;
                            end
                        end
                    endcase
                end
            end
            ST_POP: begin
                n_valid = 1'b1;
                n_value = w_rdata;
                n_state = ST_IDLE;
            end
            ST_SCAN: begin
                if (r_is_mm) begin
                    if (w_rdata < r_lo) begin
                        n_lo = w_rdata;
                    end
                    if (w_rdata > r_hi) begin
                        n_hi = w_rdata;
                    end
                end else if (w_rdata == r_key) begin
                    if (r_pend) begin
                        n_valid = 1'b1;
                        n_found = 1'b1;
                        n_pos   = r_pend_pos;
                        n_last  = 1'b0;
                    end
                    n_pend     = 1'b1;
                    n_pend_pos = r_addr;
                end
                if (r_addr == '0) begin
                    n_state = ST_FLUSH;
                end else begin
                    n_addr = r_addr - AW'(1);
                end
            end
            ST_FLUSH: begin
                n_valid = 1'b1;
                if (r_is_mm) begin
                    n_value = r_lo;
                    n_max   = r_hi;
                end else if (r_pend) begin
                    n_found = 1'b1;
                    n_pos   = r_pend_pos;
                end
                n_state = ST_IDLE;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_cnt   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_valid <= n_valid;
        end
        r_addr     <= n_addr;
        r_key      <= n_key;
        r_is_mm    <= n_is_mm;
        r_lo       <= n_lo;
        r_hi       <= n_hi;
        r_pend     <= n_pend;
        r_pend_pos <= n_pend_pos;
        r_status   <= n_status;
        r_value    <= n_value;
        r_max      <= n_max;
        r_found    <= n_found;
        r_pos      <= n_pos;
        r_last     <= n_last;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_valid     = r_valid;
    assign o_status    = r_status;
    assign o_value     = r_value;
    assign o_max_value = r_max;
    assign o_found     = r_found;
    assign o_position  = stksrch_pkg::POS_W'(r_pos);
    assign o_occupancy = stksrch_pkg::OCC_W'(r_cnt);
    assign o_last      = r_last;

    assign w_pop_st    = (r_state == ST_POP);
    assign w_push_ok   = start && !busy && (i_mode == stksrch_pkg::MODE_PUSH)
                         && (r_cnt != CW'(DEPTH));
    assign w_cnt_inc   = r_cnt + CW'(1);
    assign w_match_out = o_valid && o_found;
    assign w_pos_ok    = (stksrch_pkg::OCC_W'(o_position) < o_occupancy);

    `ASSERT_NEVER(a_cnt_bound, i_clk, i_rst_n, r_cnt > CW'(DEPTH), "fill count above depth")
    `ASSERT_CLK(a_pop_result, i_clk, i_rst_n, w_pop_st |=> (o_valid && o_last), "pop lost")
    `ASSERT_CLK(a_push_count, i_clk, i_rst_n, w_push_ok |=> (r_cnt == $past(w_cnt_inc)), "push lost")
    `ASSERT_CLK(a_found_pos, i_clk, i_rst_n, w_match_out |-> w_pos_ok, "match above top")

endmodule

[rtl/stksrch_ram.sv]
module stksrch_ram #(
    parameter int DEPTH = stksrch_pkg::DEPTH_DEF,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic                i_clk,
    input  logic                i_we,
    input  logic [AW-1:0]       i_waddr,
    input  stksrch_pkg::t_word  i_wdata,
    input  logic [AW-1:0]       i_raddr,
    output stksrch_pkg::t_word  o_rdata
);

    stksrch_pkg::t_word r_mem [DEPTH];
    stksrch_pkg::t_word r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sim/tb_top.sv]
module tb_top;

    localparam int DEPTH      = stksrch_pkg::DEPTH_DEF;
    localparam int RAND_ITEMS = 355;
    localparam int CYCLE_CAP  = 200000;

    typedef struct packed {
        logic [stksrch_pkg::STAT_W-1:0] status;
        stksrch_pkg::t_word             value;
        stksrch_pkg::t_word             max_value;
        logic                           found;
        logic [stksrch_pkg::POS_W-1:0]  position;
        logic [stksrch_pkg::OCC_W-1:0]  occupancy;
        logic                           last;
    } t_stack_result;

    typedef struct packed {
        logic [stksrch_pkg::MODE_W-1:0] mode;
        stksrch_pkg::t_word             data;
        logic                           given;
        t_stack_result                  want;
    } t_stack_cmd;

    logic                           i_clk;
    logic                           i_rst_n;
    logic                           start;
    logic                           busy;
    logic [stksrch_pkg::MODE_W-1:0] i_mode;
    stksrch_pkg::t_word             i_data;
    logic                           o_valid;
    logic [stksrch_pkg::STAT_W-1:0] o_status;
    stksrch_pkg::t_word             o_value;
    stksrch_pkg::t_word             o_max_value;
    logic                           o_found;
    logic [stksrch_pkg::POS_W-1:0]  o_position;
    logic [stksrch_pkg::OCC_W-1:0]  o_occupancy;
    logic                           o_last;

    stksrch_pkg::t_word  shadow_mem [DEPTH];
    int                  shadow_fill;
    t_stack_result       scan_results[$];
    t_stack_result       expected_results[$];
    t_stack_result       head;
    bit                  failed;
    int                  cycle_count = 0;

    array_stack_with_search_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_mode      (i_mode),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .o_status    (o_status),
        .o_value     (o_value),
        .o_max_value (o_max_value),
        .o_found     (o_found),
        .o_position  (o_position),
        .o_occupancy (o_occupancy),
        .o_last      (o_last)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic void predict_stack_op(input logic [stksrch_pkg::MODE_W-1:0] m,
                                             input stksrch_pkg::t_word d);
        t_stack_result      r;
        stksrch_pkg::t_word lo;
        stksrch_pkg::t_word hi;
        int                 i;
        r = '0;
        scan_results.delete();
        case (m)
            stksrch_pkg::MODE_PUSH: begin
                if (shadow_fill >= DEPTH) begin
                    r.status = stksrch_pkg::STAT_FULL;
                end else begin
                    shadow_mem[shadow_fill] = d;
                    shadow_fill++;
                end
            end
            stksrch_pkg::MODE_POP: begin
                if (shadow_fill == 0) begin
                    r.status = stksrch_pkg::STAT_EMPTY;
                end else begin
                    shadow_fill--;
                    r.value = shadow_mem[shadow_fill];
                end
            end
            stksrch_pkg::MODE_SEARCH: begin
                for (i = shadow_fill - 1; i >= 0; i--) begin
                    if (shadow_mem[i] == d) begin
                        r.found     = 1'b1;
                        r.position  = i[stksrch_pkg::POS_W-1:0];
                        r.occupancy = shadow_fill[stksrch_pkg::OCC_W-1:0];
                        scan_results.push_back(r);
                    end
                end
                r.found    = 1'b0;
                r.position = '0;
            end
            default: begin
                lo = stksrch_pkg::WORD_MAX;
                hi = stksrch_pkg::WORD_MIN;
                for (i = shadow_fill - 1; i >= 0; i--) begin
                    if (shadow_mem[i] < lo) lo = shadow_mem[i];
                    if (shadow_mem[i] > hi) hi = shadow_mem[i];
                end
                r.value     = lo;
                r.max_value = hi;
            end
        endcase
        if (scan_results.size() == 0) begin
            r.occupancy = shadow_fill[stksrch_pkg::OCC_W-1:0];
            r.last      = 1'b1;
            scan_results.push_back(r);
        end else begin
            scan_results[scan_results.size() - 1].last = 1'b1;
        end
    endfunction

    function automatic t_stack_cmd plain_cmd(input logic [stksrch_pkg::MODE_W-1:0] m,
                                             input stksrch_pkg::t_word d);
        t_stack_cmd c;
        c      = '0;
        c.mode = m;
        c.data = d;
        return c;
    endfunction

    function automatic t_stack_cmd checked_cmd(input logic [stksrch_pkg::MODE_W-1:0] m,
                                               input stksrch_pkg::t_word d,
                                               input logic [stksrch_pkg::STAT_W-1:0] st,
                                               input stksrch_pkg::t_word v,
                                               input stksrch_pkg::t_word mx,
                                               input int occ);
        t_stack_cmd c;
        c                = plain_cmd(m, d);
        c.given          = 1'b1;
        c.want.status    = st;
        c.want.value     = v;
        c.want.max_value = mx;
        c.want.occupancy = occ[stksrch_pkg::OCC_W-1:0];
        c.want.last      = 1'b1;
        return c;
    endfunction

    function automatic stksrch_pkg::t_word corner_word();
        case ($urandom_range(7))
            0: return stksrch_pkg::WORD_MIN;
            1: return stksrch_pkg::WORD_MAX;
            2: return '0;
            3: return -1;
            default: return stksrch_pkg::t_word'($urandom_range(4));
        endcase
    endfunction

    task automatic issue_cmd(input t_stack_cmd c, input int idle_pct);
        int k;
        if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
            start  <= 1'b0;
            i_data <= stksrch_pkg::t_word'($urandom);
            do @(posedge i_clk); while ($urandom_range(99) < idle_pct);
        end
        start  <= 1'b1;
        i_mode <= c.mode;
        i_data <= c.data;
        do @(posedge i_clk); while (busy);
        predict_stack_op(c.mode, c.data);
        if (c.given) begin
            expected_results.push_back(c.want);
        end else begin
            for (k = 0; k < scan_results.size(); k++) expected_results.push_back(scan_results[k]);
        end
    endtask

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_CAP) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid) begin
            if (expected_results.size() == 0) begin
                $error("unexpected result transfer");
                failed = 1'b1;
            end else begin
                head = expected_results.pop_front();
                if (o_status !== head.status) begin
                    $error("status: expected %0d, got %0d", head.status, o_status);
                    failed = 1'b1;
                end
                if (o_value !== head.value) begin
                    $error("value: expected %0d, got %0d", head.value, o_value);
                    failed = 1'b1;
                end
                if (o_max_value !== head.max_value) begin
                    $error("max_value: expected %0d, got %0d", head.max_value, o_max_value);
                    failed = 1'b1;
                end
                if (o_found !== head.found) begin
                    $error("found: expected %0d, got %0d", head.found, o_found);
                    failed = 1'b1;
                end
                if (o_position !== head.position) begin
                    $error("position: expected %0d, got %0d", head.position, o_position);
                    failed = 1'b1;
                end
                if (o_occupancy !== head.occupancy) begin
                    $error("occupancy: expected %0d, got %0d", head.occupancy, o_occupancy);
                    failed = 1'b1;
                end
                if (o_last !== head.last) begin
                    $error("last: expected %0d, got %0d", head.last, o_last);
                    failed = 1'b1;
                end
            end
        end
    end

    initial begin
        t_stack_cmd                     plan[$];
        t_stack_cmd                     c;
        int                             idle_pcts[4];
        int                             n;
        int                             target;
        int                             pick;
        logic [stksrch_pkg::MODE_W-1:0] m;
        stksrch_pkg::t_word             d;

        failed      = 1'b0;
        shadow_fill = 0;
        idle_pcts   = '{0, 61, 0, 6};
        i_rst_n <= 1'b0;
        start   <= 1'b0;
        i_mode  <= stksrch_pkg::MODE_PUSH;
        i_data  <= '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        plan.push_back(checked_cmd(stksrch_pkg::MODE_MINMAX, 32'sd7, stksrch_pkg::STAT_OK,
                                   stksrch_pkg::WORD_MAX, stksrch_pkg::WORD_MIN, 0));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_POP, -1, stksrch_pkg::STAT_EMPTY,
                                   '0, '0, 0));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_SEARCH, '0, stksrch_pkg::STAT_OK,
                                   '0, '0, 0));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_PUSH, stksrch_pkg::WORD_MIN,
                                   stksrch_pkg::STAT_OK, '0, '0, 1));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_PUSH, stksrch_pkg::WORD_MAX,
                                   stksrch_pkg::STAT_OK, '0, '0, 2));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_PUSH, '0, stksrch_pkg::STAT_OK,
                                   '0, '0, 3));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_PUSH, -1, stksrch_pkg::STAT_OK,
                                   '0, '0, 4));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_PUSH, stksrch_pkg::WORD_MAX,
                                   stksrch_pkg::STAT_OK, '0, '0, 5));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_SEARCH, stksrch_pkg::WORD_MAX));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_SEARCH, 32'sd12345));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_SEARCH, -1));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_MINMAX, '0, stksrch_pkg::STAT_OK,
                                   stksrch_pkg::WORD_MIN, stksrch_pkg::WORD_MAX, 5));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_POP, stksrch_pkg::WORD_MIN,
                                   stksrch_pkg::STAT_OK, stksrch_pkg::WORD_MAX, '0, 4));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_POP, '0, stksrch_pkg::STAT_OK,
                                   -1, '0, 3));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_SEARCH, stksrch_pkg::WORD_MIN));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_MINMAX, -1));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_PUSH, 32'sh5555_5555));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_PUSH, 32'shAAAA_AAAA));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_POP, '0));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_POP, 32'sh5555_5555));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_POP, '0));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_POP, 32'shAAAA_AAAA));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_POP, '0));
        plan.push_back(checked_cmd(stksrch_pkg::MODE_POP, '0, stksrch_pkg::STAT_EMPTY,
                                   '0, '0, 0));
        plan.push_back(plain_cmd(stksrch_pkg::MODE_MINMAX, stksrch_pkg::WORD_MAX));
        foreach (plan[i]) issue_cmd(plan[i], 0);

        // first walk overfills to hit the full refusal
        target = DEPTH + 2;
        for (n = 0; n < RAND_ITEMS; n++) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                if (shadow_fill == target) begin
                    case ($urandom_range(3))
                        0: target = -2;
                        1: target = DEPTH + 2;
                        default: target = $urandom_range(DEPTH);
                    endcase
                end
                if (target > DEPTH && shadow_fill == DEPTH) begin
                    m = stksrch_pkg::MODE_PUSH;
                    target--;
                end else if (target < 0 && shadow_fill == 0) begin
                    m = stksrch_pkg::MODE_POP;
                    target++;
                end else if (shadow_fill < target) begin
                    m = stksrch_pkg::MODE_PUSH;
                end else begin
                    m = stksrch_pkg::MODE_POP;
                end
                d = ($urandom_range(99) < 40) ? corner_word()
                                              : stksrch_pkg::t_word'($urandom);
            end else if (pick < 85) begin
                m = stksrch_pkg::MODE_SEARCH;
                if (shadow_fill > 0 && $urandom_range(1) == 1)
                    d = shadow_mem[$urandom_range(shadow_fill - 1)];
                else if ($urandom_range(1) == 1)
                    d = corner_word();
                else
                    d = stksrch_pkg::t_word'($urandom);
            end else if (pick < 95) begin
                m = stksrch_pkg::MODE_MINMAX;
                d = stksrch_pkg::t_word'($urandom);
            end else begin
                m = stksrch_pkg::MODE_W'($urandom_range(3));
                d = stksrch_pkg::t_word'($urandom);
            end
            issue_cmd(plain_cmd(m, d), idle_pcts[n * 4 / RAND_ITEMS]);
        end
        start <= 1'b0;

        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (DEPTH + 8) @(posedge i_clk);
        if (!failed && expected_results.size() == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

[filelist.f]
+incdir+rtl
rtl/stksrch_pkg.sv
rtl/stksrch_ram.sv
rtl/array_stack_with_search_core.sv
sim/tb_top.sv
